// ===== rtl/core/scaf_pkg.sv =====
package scaf_pkg;

  localparam int unsigned CmdMaxBits    = 16;
  localparam int unsigned AddrMaxBits   = 32;
  localparam int unsigned ByteBits      = 8;
  localparam int unsigned MinBits       = 4;
  localparam int unsigned MaxTotalBits  = 64;
  localparam int unsigned SingleMaxBits = 16;

  localparam int unsigned CmdW     = 16;
  localparam int unsigned CmdLenW  = 5;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned AddrLenW = 6;
  localparam int unsigned DummyW   = 6;
  localparam int unsigned WordW    = 16;
  localparam int unsigned SizeW    = 5;
  localparam int unsigned TotalW   = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_ADDR,
    ST_DUMMY,
    ST_ERR
  } state_e;

  // sequencer to packer: one stream bit or a request control
  typedef struct packed {
    logic             start;
    logic [SizeW-1:0] first_size;
    logic             bit_vld;
    logic             bit_val;
    logic             bit_last;
    logic             err;
  } pack_ctrl_t;

endpackage

// ===== rtl/core/scaf_req_if.sv =====
interface scaf_req_if;
  logic                             valid;
  logic                             ready;
  logic [scaf_pkg::CmdW-1:0]        command;
  logic [scaf_pkg::CmdLenW-1:0]     command_length;
  logic [scaf_pkg::AddrW-1:0]       address;
  logic [scaf_pkg::AddrLenW-1:0]    address_length;
  logic [scaf_pkg::DummyW-1:0]      dummy_length;
  logic                             lsb_first;

  modport source (
    output valid, command, command_length, address, address_length, dummy_length, lsb_first,
    input  ready
  );
  modport sink (
    input  valid, command, command_length, address, address_length, dummy_length, lsb_first,
    output ready
  );
endinterface

// ===== rtl/core/scaf_word_if.sv =====
interface scaf_word_if;
  logic                         valid;
  logic                         ready;
  logic [scaf_pkg::WordW-1:0]   fifo_word;
  logic [scaf_pkg::SizeW-1:0]   word_size;
  logic                         last_word;
  logic                         length_error;

  modport source (
    output valid, fifo_word, word_size, last_word, length_error,
    input  ready
  );
  modport sink (
    input  valid, fifo_word, word_size, last_word, length_error,
    output ready
  );
endinterface

// ===== rtl/core/spi_command_address_framer.sv =====
// SPI command / address / dummy framer.
// req_i takes one request header (command, address, dummy count, bit order);
// word_o gives the transmit FIFO words for it, most significant bits first.
// Both channels use valid/ready; a word moves when both are high.
// The header is taken while idle; the bit string is then built one bit
// per cycle, while the output register can take it, into a 16-bit shift
// register. The output register takes each word when its last bit is
// taken; words after the first hold a byte each. A request with a bad
// total gives a single error word; a zero total gives nothing.
// The next header is taken as soon as the last bit of the previous one is
// in the output register, even while that word waits to be taken.
// When the receiver stalls with a word pending, bit generation holds until
// the word is taken; nothing is dropped.
// Reset clears the sequencer and the output valid; no word is pending.
module spi_command_address_framer (
  input  logic         clk_i,
  input  logic         rst_ni,
  scaf_req_if.sink     req_i,
  scaf_word_if.source  word_o
);

  scaf_pkg::state_e     state_q, state_d;
  scaf_pkg::pack_ctrl_t ctrl;
  logic                 bit_rdy;

  logic [scaf_pkg::CmdW-1:0]     cmd_q;
  logic [scaf_pkg::AddrW-1:0]    addr_q;
  logic [scaf_pkg::CmdLenW-1:0]  cl_q;
  logic [scaf_pkg::AddrLenW-1:0] al_q;
  logic                          lsb_q;
  logic [4:0]                    pos_q, pos_d;
  logic [scaf_pkg::TotalW-1:0]   rem_q, rem_d;

  logic [scaf_pkg::CmdLenW-1:0]  cl_c;
  logic [scaf_pkg::AddrLenW-1:0] al_c;
  logic [scaf_pkg::TotalW-1:0]   total;
  logic                          accept, load;
  logic [4:0]                    cmd_rev;
  logic [5:0]                    addr_rev;
  logic [3:0]                    cmd_idx;
  logic [4:0]                    addr_idx;

  assign cl_c = (req_i.command_length > scaf_pkg::CmdLenW'(scaf_pkg::CmdMaxBits))
              ? scaf_pkg::CmdLenW'(scaf_pkg::CmdMaxBits) : req_i.command_length;
  assign al_c = (req_i.address_length > scaf_pkg::AddrLenW'(scaf_pkg::AddrMaxBits))
              ? scaf_pkg::AddrLenW'(scaf_pkg::AddrMaxBits) : req_i.address_length;
  assign total = scaf_pkg::TotalW'(cl_c) + scaf_pkg::TotalW'(al_c)
               + scaf_pkg::TotalW'(req_i.dummy_length);

  assign req_i.ready = (state_q == scaf_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // MSB-first walks down from the top of the field, LSB-first walks up
  assign cmd_rev  = cl_q - 5'd1 - pos_q;
  assign addr_rev = al_q - 6'd1 - {1'b0, pos_q};
  assign cmd_idx  = lsb_q ? pos_q[3:0] : cmd_rev[3:0];
  assign addr_idx = lsb_q ? pos_q : addr_rev[4:0];

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    load    = 1'b0;
    ctrl    = '0;
    ctrl.bit_last = (rem_q == scaf_pkg::TotalW'(1));
    case (state_q)
      scaf_pkg::ST_IDLE: begin
        if (accept && total != '0) begin
          if (total < scaf_pkg::TotalW'(scaf_pkg::MinBits)
              || total > scaf_pkg::TotalW'(scaf_pkg::MaxTotalBits)) begin
            state_d = scaf_pkg::ST_ERR;
          end else begin
            load            = 1'b1;
            ctrl.start      = 1'b1;
            ctrl.first_size = (total <= scaf_pkg::TotalW'(scaf_pkg::SingleMaxBits))
                            ? total[scaf_pkg::SizeW-1:0] : {2'b01, total[2:0]};
            pos_d = '0;
            rem_d = total;
            if (cl_c != '0) begin
              state_d = scaf_pkg::ST_CMD;
            end else if (al_c != '0) begin
              state_d = scaf_pkg::ST_ADDR;
            end else begin
              state_d = scaf_pkg::ST_DUMMY;
            end
          end
        end
      end
      scaf_pkg::ST_CMD, scaf_pkg::ST_ADDR, scaf_pkg::ST_DUMMY: begin
        ctrl.bit_vld = 1'b1;
        case (state_q)
          scaf_pkg::ST_CMD:  ctrl.bit_val = cmd_q[cmd_idx];
          scaf_pkg::ST_ADDR: ctrl.bit_val = addr_q[addr_idx];
          default:           ctrl.bit_val = 1'b0;
        endcase
        if (bit_rdy) begin
          rem_d = rem_q - scaf_pkg::TotalW'(1);
          pos_d = pos_q + 5'd1;
          if (ctrl.bit_last) begin
            state_d = scaf_pkg::ST_IDLE;
          end else if (state_q == scaf_pkg::ST_CMD && cmd_rev == '0) begin
            pos_d   = '0;
            state_d = (al_q != '0) ? scaf_pkg::ST_ADDR : scaf_pkg::ST_DUMMY;
          end else if (state_q == scaf_pkg::ST_ADDR
                       && {1'b0, pos_q} == al_q - 6'd1) begin
            pos_d   = '0;
            state_d = scaf_pkg::ST_DUMMY;
          end
        end
      end
      scaf_pkg::ST_ERR: begin
        ctrl.err = 1'b1;
        if (bit_rdy) begin
          state_d = scaf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = scaf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scaf_pkg::ST_IDLE;
      pos_q   <= '0;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q  <= req_i.command;
      addr_q <= req_i.address;
      cl_q   <= cl_c;
      al_q   <= al_c;
      lsb_q  <= req_i.lsb_first;
    end
  end

  scaf_packer u_packer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .bit_rdy_o (bit_rdy),
    .word_o    (word_o)
  );

endmodule

// ===== rtl/core/scaf_packer.sv =====
module scaf_packer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scaf_pkg::pack_ctrl_t   ctrl_i,
  output logic                   bit_rdy_o,
  scaf_word_if.source            word_o
);

  logic [scaf_pkg::WordW-1:0] acc_q, acc_d, acc_sh;
  logic [scaf_pkg::SizeW-1:0] wcnt_q, wcnt_d, wsize_q, wsize_d;
  logic                       ovld_q, ovld_d;
  logic [scaf_pkg::WordW-1:0] oword_q, oword_d;
  logic [scaf_pkg::SizeW-1:0] osize_q, osize_d;
  logic                       olast_q, olast_d, oerr_q, oerr_d;
  logic                       take, wdone;

  assign bit_rdy_o = !ovld_q || word_o.ready;
  assign take      = ctrl_i.bit_vld && bit_rdy_o;
  assign acc_sh    = {acc_q[scaf_pkg::WordW-2:0], ctrl_i.bit_val};
  assign wdone     = (wcnt_q + scaf_pkg::SizeW'(1)) == wsize_q;

  always_comb begin
    acc_d   = acc_q;
    wcnt_d  = wcnt_q;
    wsize_d = wsize_q;
    ovld_d  = ovld_q;
    oword_d = oword_q;
    osize_d = osize_q;
    olast_d = olast_q;
    oerr_d  = oerr_q;
    if (ovld_q && word_o.ready) begin
      ovld_d = 1'b0;
    end
    if (ctrl_i.start) begin
      acc_d   = '0;
      wcnt_d  = '0;
      wsize_d = ctrl_i.first_size;
    end else if (take) begin
      if (wdone) begin
        // word complete: hand it to the output register, start a byte
        ovld_d  = 1'b1;
        oword_d = acc_sh;
        osize_d = wsize_q;
        olast_d = ctrl_i.bit_last;
        oerr_d  = 1'b0;
        acc_d   = '0;
        wcnt_d  = '0;
        wsize_d = scaf_pkg::SizeW'(scaf_pkg::ByteBits);
      end else begin
        acc_d  = acc_sh;
        wcnt_d = wcnt_q + scaf_pkg::SizeW'(1);
      end
    end else if (ctrl_i.err && bit_rdy_o) begin
      ovld_d  = 1'b1;
      oword_d = '0;
      osize_d = '0;
      olast_d = 1'b1;
      oerr_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
      wcnt_q <= '0;
    end else begin
      ovld_q <= ovld_d;
      wcnt_q <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    wsize_q <= wsize_d;
    oword_q <= oword_d;
    osize_q <= osize_d;
    olast_q <= olast_d;
    oerr_q  <= oerr_d;
  end

  assign word_o.valid        = ovld_q;
  assign word_o.fifo_word    = oword_q;
  assign word_o.word_size    = osize_q;
  assign word_o.last_word    = olast_q;
  assign word_o.length_error = oerr_q;

endmodule

// ===== rtl/core/scaf_checker.sv =====
module scaf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic [scaf_pkg::CmdLenW-1:0]    req_cl_i,
  input logic [scaf_pkg::AddrLenW-1:0]   req_al_i,
  input logic [scaf_pkg::DummyW-1:0]     req_dl_i,
  input logic                            wrd_valid_i,
  input logic                            wrd_ready_i,
  input logic [scaf_pkg::WordW-1:0]      wrd_word_i,
  input logic [scaf_pkg::SizeW-1:0]      wrd_size_i,
  input logic                            wrd_last_i,
  input logic                            wrd_err_i
);

  logic busy_req;

  // any nonzero total leaves the sequencer busy after the header is taken
  assign busy_req = (req_cl_i != '0) || (req_al_i != '0) || (req_dl_i != '0);

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrd_valid_i && wrd_err_i |-> wrd_size_i == '0 && wrd_last_i && wrd_word_i == '0)
    else $error("error word malformed");

  a_good_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrd_valid_i && !wrd_err_i |-> wrd_size_i >= scaf_pkg::SizeW'(scaf_pkg::MinBits))
    else $error("good word shorter than minimum");

  a_mid_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrd_valid_i && !wrd_last_i |-> wrd_size_i >= scaf_pkg::SizeW'(scaf_pkg::ByteBits)
                                   && !wrd_err_i)
    else $error("non-final word shorter than a byte");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && busy_req |=> !req_ready_i)
    else $error("header taken while previous one still in work");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrd_valid_i && !wrd_ready_i |=> wrd_valid_i && $stable(wrd_word_i)
                                    && $stable(wrd_size_i))
    else $error("stalled word changed");

endmodule

bind spi_command_address_framer scaf_checker u_scaf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_cl_i    (req_i.command_length),
  .req_al_i    (req_i.address_length),
  .req_dl_i    (req_i.dummy_length),
  .wrd_valid_i (word_o.valid),
  .wrd_ready_i (word_o.ready),
  .wrd_word_i  (word_o.fifo_word),
  .wrd_size_i  (word_o.word_size),
  .wrd_last_i  (word_o.last_word),
  .wrd_err_i   (word_o.length_error)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned DrainCycles   = 100;

  typedef struct packed {
    logic [scaf_pkg::CmdW-1:0]     command;
    logic [scaf_pkg::CmdLenW-1:0]  command_length;
    logic [scaf_pkg::AddrW-1:0]    address;
    logic [scaf_pkg::AddrLenW-1:0] address_length;
    logic [scaf_pkg::DummyW-1:0]   dummy_length;
    logic                          lsb_first;
  } header_t;

  typedef struct packed {
    logic [scaf_pkg::WordW-1:0] fifo_word;
    logic [scaf_pkg::SizeW-1:0] word_size;
    logic                       last_word;
    logic                       length_error;
  } fifo_word_t;

  // Expected FIFO words of every accepted header, oldest first.
  class fifo_word_ledger;
    fifo_word_t due_words[$];
    int unsigned mismatches;
    int unsigned n_headers;
    int unsigned n_words;
    int unsigned n_error_words;
    int unsigned n_lsb_first;

    function new();
      mismatches    = 0;
      n_headers     = 0;
      n_words       = 0;
      n_error_words = 0;
      n_lsb_first   = 0;
    endfunction

    function logic [63:0] low_bits(logic [63:0] v, int unsigned n);
      if (n >= 64) return v;
      return v & ((64'd1 << n) - 64'd1);
    endfunction

    function logic [63:0] mirror(logic [63:0] v, int unsigned n);
      logic [63:0] r;
      r = '0;
      for (int unsigned i = 0; i < n; i++) r = (r << 1) | 64'(v[i]);
      return r;
    endfunction

    function void add_word(logic [63:0] data, int unsigned size, bit last, bit err);
      fifo_word_t w;
      w.fifo_word    = data[scaf_pkg::WordW-1:0];
      w.word_size    = scaf_pkg::SizeW'(size);
      w.last_word    = last;
      w.length_error = err;
      due_words.push_back(w);
    endfunction

    // Split the command / address / dummy bit string into FIFO words.
    function void frame_header(header_t h);
      int unsigned cl, al, dl, total, first, rest;
      logic [63:0] cmd, addr, bits;
      n_headers++;
      if (h.lsb_first) n_lsb_first++;
      cl = (h.command_length > scaf_pkg::CmdMaxBits)
         ? scaf_pkg::CmdMaxBits : 32'(h.command_length);
      al = (h.address_length > scaf_pkg::AddrMaxBits)
         ? scaf_pkg::AddrMaxBits : 32'(h.address_length);
      dl = 32'(h.dummy_length);
      total = cl + al + dl;
      if (total == 0) return;
      if (total < scaf_pkg::MinBits || total > scaf_pkg::MaxTotalBits) begin
        add_word('0, 0, 1'b1, 1'b1);
        return;
      end
      cmd  = low_bits(64'(h.command), cl);
      addr = low_bits(64'(h.address), al);
      if (h.lsb_first) begin
        cmd  = mirror(cmd, cl);
        addr = mirror(addr, al);
      end
      bits = ((cmd << al) | addr) << dl;
      if (total <= scaf_pkg::SingleMaxBits) begin
        add_word(bits, total, 1'b1, 1'b0);
        return;
      end
      first = (total % scaf_pkg::ByteBits) + scaf_pkg::ByteBits;
      rest  = total - first;
      add_word(low_bits(bits >> rest, first), first, rest == 0, 1'b0);
      while (rest != 0) begin
        rest -= scaf_pkg::ByteBits;
        add_word(low_bits(bits >> rest, scaf_pkg::ByteBits), scaf_pkg::ByteBits,
                 rest == 0, 1'b0);
      end
    endfunction

    function void check_word(fifo_word_t got);
      fifo_word_t exp;
      n_words++;
      if (got.length_error) n_error_words++;
      if (due_words.size() == 0) begin
        $error("unexpected word: fifo_word %h size %0d last %0d err %0d",
               got.fifo_word, got.word_size, got.last_word, got.length_error);
        mismatches++;
        return;
      end
      exp = due_words.pop_front();
      if (got.fifo_word !== exp.fifo_word) begin
        $error("fifo_word: expected %h, actual %h", exp.fifo_word, got.fifo_word);
        mismatches++;
      end
      if (got.word_size !== exp.word_size) begin
        $error("word_size: expected %0d, actual %0d", exp.word_size, got.word_size);
        mismatches++;
      end
      if (got.last_word !== exp.last_word) begin
        $error("last_word: expected %0d, actual %0d", exp.last_word, got.last_word);
        mismatches++;
      end
      if (got.length_error !== exp.length_error) begin
        $error("length_error: expected %0d, actual %0d", exp.length_error, got.length_error);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  scaf_req_if  req_if ();
  scaf_word_if word_if ();

  spi_command_address_framer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .word_o (word_if)
  );

  fifo_word_ledger ledger;
  bit              sender_gaps;
  bit              quiet;
  bit              hold_req;
  bit              hold_done;
  int unsigned     idle_cycles;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic header_t make_header(logic [15:0] cmd, logic [4:0] cl,
                                          logic [31:0] addr, logic [5:0] al,
                                          logic [5:0] dl, logic lsb);
    header_t h;
    h.command        = cmd;
    h.command_length = cl;
    h.address        = addr;
    h.address_length = al;
    h.dummy_length   = dl;
    h.lsb_first      = lsb;
    return h;
  endfunction

  // Mostly legal totals with random content; the rest hits the odd lengths.
  function automatic header_t random_header();
    header_t h;
    h.command        = 16'($urandom);
    h.address        = $urandom;
    h.lsb_first      = 1'($urandom);
    h.command_length = 5'($urandom_range(0, 16));
    h.address_length = 6'($urandom_range(0, 32));
    h.dummy_length   = 6'($urandom_range(0, 16));
    case ($urandom_range(0, 19))
      0: begin
        h.command_length = '0;
        h.address_length = '0;
        h.dummy_length   = '0;
      end
      1: begin
        h.command_length = 5'($urandom_range(0, 1));
        h.address_length = 6'($urandom_range(0, 1));
        h.dummy_length   = 6'd1;
      end
      2: begin
        h.command_length = 5'($urandom);
        h.address_length = 6'($urandom);
        h.dummy_length   = 6'($urandom);
      end
      3: h.command_length = 5'($urandom_range(17, 31));
      4: begin
        h.address_length = 6'($urandom_range(33, 63));
        h.dummy_length   = 6'($urandom_range(0, 32));
      end
      5: begin
        h.address_length = 6'($urandom_range(0, 16));
        h.dummy_length   = 6'($urandom_range(17, 32));
      end
      default: ;
    endcase
    return h;
  endfunction

  task automatic send_header(header_t h);
    req_if.valid          <= 1'b1;
    req_if.command        <= h.command;
    req_if.command_length <= h.command_length;
    req_if.address        <= h.address;
    req_if.address_length <= h.address_length;
    req_if.dummy_length   <= h.dummy_length;
    req_if.lsb_first      <= h.lsb_first;
    do @(posedge clk_i); while (!req_if.ready);
    ledger.frame_header(h);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_header(random_header());
  endtask

  // Drop valid and hold until every expected word has been taken.
  task automatic drain_words();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (ledger.due_words.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && word_if.valid && word_if.ready) begin
      ledger.check_word({word_if.fifo_word, word_if.word_size,
                         word_if.last_word, word_if.length_error});
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (word_if.valid && word_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : receiver
    word_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        word_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        word_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        word_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    ledger      = new();
    sender_gaps = 1'b0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.command        <= '0;
    req_if.command_length <= '0;
    req_if.address        <= '0;
    req_if.address_length <= '0;
    req_if.dummy_length   <= '0;
    req_if.lsb_first      <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_header(make_header(16'h0000, 5'd0, 32'h0, 6'd0, 6'd0, 1'b0));
    send_header(make_header(16'h0001, 5'd1, 32'h0, 6'd0, 6'd0, 1'b0));
    send_header(make_header(16'h0000, 5'd0, 32'h3, 6'd2, 6'd0, 1'b1));
    send_header(make_header(16'h0000, 5'd0, 32'h0, 6'd0, 6'd3, 1'b0));
    send_header(make_header(16'h000F, 5'd4, 32'h0, 6'd0, 6'd0, 1'b0));
    send_header(make_header(16'h0009, 5'd4, 32'h0, 6'd0, 6'd0, 1'b1));
    send_header(make_header(16'hA5C3, 5'd16, 32'h0, 6'd0, 6'd0, 1'b0));
    send_header(make_header(16'hA5C3, 5'd16, 32'h0, 6'd0, 6'd0, 1'b1));
    send_header(make_header(16'hFFFF, 5'd16, 32'h1, 6'd1, 6'd0, 1'b0));
    send_header(make_header(16'h0012, 5'd8, 32'h3456, 6'd16, 6'd0, 1'b0));
    send_header(make_header(16'h007F, 5'd7, 32'hABCD, 6'd16, 6'd0, 1'b1));
    send_header(make_header(16'hFFFF, 5'd16, 32'hFFFF_FFFF, 6'd32, 6'd16, 1'b1));
    send_header(make_header(16'hFFFF, 5'd16, 32'hFFFF_FFFF, 6'd32, 6'd17, 1'b0));
    send_header(make_header(16'hFFFF, 5'd31, 32'h0, 6'd0, 6'd0, 1'b0));
    send_header(make_header(16'h0000, 5'd0, 32'h8000_0001, 6'd63, 6'd0, 1'b1));
    send_header(make_header(16'h0000, 5'd0, 32'h0, 6'd0, 6'd32, 1'b0));
    send_header(make_header(16'h0000, 5'd0, 32'h0, 6'd0, 6'd63, 1'b0));
    send_header(make_header(16'hFFFF, 5'd31, 32'hFFFF_FFFF, 6'd63, 6'd63, 1'b1));
    send_header(make_header(16'hBEEF, 5'd16, 32'hDEAD_BEEF, 6'd32, 6'd0, 1'b0));
    send_header(make_header(16'hFFF9, 5'd3, 32'h5, 6'd3, 6'd2, 1'b1));
    send_header(make_header(16'h0000, 5'd0, 32'hFFFF_FFF5, 6'd4, 6'd0, 1'b0));

    sender_gaps = 1'b1;
    send_random(150);

    // Long receiver hold-off while headers keep coming, so the block backs up.
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    send_random(40);
    drain_words();

    sender_gaps = 1'b1;
    send_random(80);

    sender_gaps = 1'b0;
    quiet       = 1'b1;
    send_random(40);

    drain_words();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d FIFO words from %0d headers (%0d length-error words, %0d LSB-first)",
             ledger.n_words, ledger.n_headers, ledger.n_error_words, ledger.n_lsb_first);
    $display("Run included edge lengths, random stalls, a %0d-cycle hold-off and a full drain",
             HoldOffCycles);
    if (ledger.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/scaf_pkg.sv
rtl/core/scaf_req_if.sv
rtl/core/scaf_word_if.sv
rtl/core/scaf_packer.sv
rtl/core/spi_command_address_framer.sv
rtl/core/scaf_checker.sv
verif/tb.sv
